FILE: rtl/multilevel_feedback_queue_scheduler_defines.svh
// Assertion macros shared by the scheduler's checker.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MLFQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlfq: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MLFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlfq: next-cycle check failed");

`endif

FILE: rtl/mlfq_pkg.sv
// Package: constants, codes and state type of the feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;

   localparam int MAX_THREADS_DEF = 16;
   localparam int LEVELS_DEF      = 15;

   localparam int BASE_W   = 20;
   localparam int PERIOD_W = 32;
   localparam int QUANT_W  = 24;
   localparam int ID_W     = 4;
   localparam int MUL_W    = 26;

   localparam logic [BASE_W-1:0]   BASE_RESET   = 20'd20000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd10000000;
   localparam logic [QUANT_W-1:0]  QUANT_MAX    = 24'hFFFFFF;

   typedef enum logic [2:0] {
      ACT_QEND   = 3'd0,
      ACT_YIELD  = 3'd1,
      ACT_EXIT   = 3'd2,
      ACT_JOIN   = 3'd3,
      ACT_MUTEX  = 3'd4,
      ACT_CREATE = 3'd5,
      ACT_WAKE   = 3'd6,
      ACT_NOP    = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_SWITCH   = 3'd0,
      ST_KEEP     = 3'd1,
      ST_NONE     = 3'd2,
      ST_DEADLOCK = 3'd3,
      ST_ACCEPTED = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      CSR_BASE_QUANTUM = 1'b0,
      CSR_BOOST_PERIOD = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CREATE,
      S_WAKE,
      S_ACC_SLICE,
      S_ACC,
      S_BSCAN,
      S_BPOP,
      S_EVENT,
      S_PICK,
      S_POP,
      S_REQUEUE,
      S_OUT_SLICE,
      S_OUT
   } state_type;

endpackage

FILE: rtl/mlfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mlfq_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/multilevel_feedback_queue_scheduler.sv
// Top level: multilevel feedback queue thread scheduler.
`timescale 1ns / 1ps
// Usage
//   req_*  : one scheduling request per handshake. req_tuser carries the
//            action; req_tdata carries thread_id, time_left, boost_to_top.
//   rsp_*  : one result per request: status in rsp_tuser, next thread,
//            quantum and new thread id in rsp_tdata.
//   csr_*  : register writes (index 0 base_quantum, 1 boost_period); write
//            only while no request is in flight. Always ready.
// Sequence
//   One request at a time. create and wake each run their own state, the unused
//   action loads the slice; a scheduling event runs accumulate, an optional
//   priority boost, event, pick, pop (when a thread is queued), a requeue for
//   a yield and, when a thread is scheduled, the slice load. The boost walk
//   scans levels 1..LEVELS-1 and moves each queued thread to level 0 through
//   the link RAM read; it sets the worst case.
// Reset
//   Synchronous, active high: only thread 0 exists and runs, all queues
//   empty, accumulator zero, registers at their defaults. The link RAM
//   needs no clearing pass.
// Stalls
//   The result sits in an output register; the next request is accepted
//   while it waits. A finished result that finds the register occupied
//   holds until rsp_tready frees it.
module multilevel_feedback_queue_scheduler
   import mlfq_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF,
   parameter int LEVELS      = LEVELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] thread_id, [27:4] time_left, [28] boost_to_top, [31:29] zero
   input  logic [31:0] req_tdata,
   // [2:0] action
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] next_thread, [27:4] quantum, [31:28] new_thread_id
   output logic [31:0] rsp_tdata,
   // [2:0] status
   output logic [2:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int TID_W = $clog2(MAX_THREADS);
   localparam int LVL_W = $clog2(LEVELS);

   state_type state_ff, state_in;

   // latched request
   action_type          action_ff;
   logic [ID_W-1:0]     tid_ff;
   logic [QUANT_W-1:0]  tleft_ff;
   logic                top_ff;

   // registers
   logic [BASE_W-1:0]   base_ff;
   logic [PERIOD_W-1:0] period_ff;

   // queue state (links live in the RAM)
   logic [TID_W-1:0]    head_ff [LEVELS];
   logic [TID_W-1:0]    tail_ff [LEVELS];
   logic [LEVELS-1:0]   nonempty_ff;
   logic [LVL_W-1:0]    level_ff [MAX_THREADS];
   logic [MAX_THREADS-1:0] inuse_ff;
   logic [MAX_THREADS-1:0] queued_ff;
   logic [TID_W-1:0]    running_ff;
   logic [TID_W-1:0]    prev_ff;
   logic [PERIOD_W-1:0] elapsed_ff;
   logic [QUANT_W-1:0]  slice_ff;
   logic [LVL_W-1:0]    bl_ff;
   logic [LVL_W-1:0]    pick_ff;
   status_type          status_ff;
   logic [ID_W-1:0]     newid_ff;

   // output register
   logic                rsp_valid_ff;
   logic [31:0]         rsp_data_ff;
   logic [2:0]          rsp_user_ff;

   // link RAM ports
   logic                link_we;
   logic [TID_W-1:0]    link_waddr, link_raddr, link_rdata;

   // push helper
   logic                push_en;
   logic [TID_W-1:0]    push_tid;
   logic [LVL_W-1:0]    push_lvl;

   logic                req_fire;
   logic [TID_W-1:0]    tid_idx;
   logic                wake_ok;
   logic                free_any;
   logic [TID_W-1:0]    free_id;
   logic [LVL_W-1:0]    top_lvl;
   logic [LVL_W-1:0]    run_lvl, dem_lvl;
   logic [5:0]          lvl_p1;
   logic [MUL_W-1:0]    prod;
   logic [QUANT_W-1:0]  slice_sat;
   logic [QUANT_W-1:0]  used;
   logic [PERIOD_W:0]   sum;
   logic [PERIOD_W-1:0] sum_sat;
   logic [TID_W-1:0]    pop_tid;
   logic [TID_W-1:0]    boost_tid;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign tid_idx = TID_W'(tid_ff);
   assign wake_ok = (9'(tid_ff) < 9'(MAX_THREADS)) && inuse_ff[tid_idx] &&
                    (tid_idx != running_ff) && !queued_ff[tid_idx];

   // lowest free id and lowest-numbered (highest priority) non-empty level
   always_comb begin
      free_any = 1'b0;
      free_id  = '0;
      for (int i = MAX_THREADS - 1; i >= 0; i--) begin
         if (!inuse_ff[i]) begin
            free_any = 1'b1;
            free_id  = TID_W'(i);
         end
      end
   end

   always_comb begin
      top_lvl = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            top_lvl = LVL_W'(i);
         end
      end
   end

   // slice of the running thread's level, saturated to the quantum width
   assign run_lvl   = level_ff[running_ff];
   assign lvl_p1    = 6'(run_lvl) + 6'd1;
   assign prod      = MUL_W'(base_ff) * MUL_W'(lvl_p1);
   assign slice_sat = (|prod[MUL_W-1:QUANT_W]) ? QUANT_MAX : prod[QUANT_W-1:0];
   assign dem_lvl   = ((LVL_W+1)'(run_lvl) + (LVL_W+1)'(1) < (LVL_W+1)'(LEVELS)) ?
                      run_lvl + LVL_W'(1) : run_lvl;

   // time accounting
   assign used    = (tleft_ff > slice_ff) ? '0 : slice_ff - tleft_ff;
   assign sum     = (PERIOD_W+1)'(elapsed_ff) + (PERIOD_W+1)'(used);
   assign sum_sat = sum[PERIOD_W] ? '1 : sum[PERIOD_W-1:0];

   assign pop_tid   = head_ff[pick_ff];
   assign boost_tid = head_ff[bl_ff];

   // push request per state
   always_comb begin
      push_en  = 1'b0;
      push_tid = '0;
      push_lvl = '0;
      case (state_ff)
         S_CREATE: begin
            push_en  = free_any;
            push_tid = free_id;
         end
         S_WAKE: begin
            push_en  = wake_ok;
            push_tid = tid_idx;
            push_lvl = top_ff ? '0 : level_ff[tid_idx];
         end
         S_BPOP: begin
            push_en  = 1'b1;
            push_tid = boost_tid;
         end
         S_EVENT: begin
            push_en  = (action_ff == ACT_QEND);
            push_tid = running_ff;
            push_lvl = dem_lvl;
         end
         S_REQUEUE: begin
            push_en  = 1'b1;
            push_tid = prev_ff;
            push_lvl = level_ff[prev_ff];
         end
         default: begin
            push_en = 1'b0;
         end
      endcase
   end

   assign link_we    = push_en && nonempty_ff[push_lvl];
   assign link_waddr = tail_ff[push_lvl];
   assign link_raddr = (state_ff == S_BSCAN) ? head_ff[bl_ff] : head_ff[top_lvl];

   mlfq_ram #(
      .WIDTH (TID_W),
      .DEPTH (MAX_THREADS)
   ) u_link (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (push_tid),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (action_type'(req_tuser))
                  ACT_CREATE: state_in = S_CREATE;
                  ACT_WAKE:   state_in = S_WAKE;
                  ACT_NOP:    state_in = S_OUT_SLICE;
                  default:    state_in = S_ACC_SLICE;
               endcase
            end
         end
         S_CREATE:    state_in = S_OUT;
         S_WAKE:      state_in = S_OUT;
         S_ACC_SLICE: state_in = S_ACC;
         S_ACC:       state_in = (sum_sat >= period_ff) ? S_BSCAN : S_EVENT;
         S_BSCAN: begin
            if (nonempty_ff[bl_ff]) begin
               state_in = S_BPOP;
            end else if (32'(bl_ff) == LEVELS - 1) begin
               state_in = S_EVENT;
            end
         end
         S_BPOP:  state_in = S_BSCAN;
         S_EVENT: state_in = S_PICK;
         S_PICK: begin
            if (nonempty_ff != '0) begin
               state_in = S_POP;
            end else if (action_ff == ACT_YIELD) begin
               state_in = S_OUT_SLICE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_POP:       state_in = (action_ff == ACT_YIELD) ? S_REQUEUE : S_OUT_SLICE;
         S_REQUEUE:   state_in = S_OUT_SLICE;
         S_OUT_SLICE: state_in = S_OUT;
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         period_ff    <= PERIOD_RESET;
         nonempty_ff  <= '0;
         inuse_ff     <= MAX_THREADS'(1);
         queued_ff    <= '0;
         running_ff   <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_THREADS; i++) begin
            level_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_BASE_QUANTUM: base_ff   <= csr_data[BASE_W-1:0];
               CSR_BOOST_PERIOD: period_ff <= csr_data;
               default:          base_ff   <= base_ff;
            endcase
         end

         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_CREATE: begin
               if (free_any) begin
                  inuse_ff[free_id] <= 1'b1;
                  level_ff[free_id] <= '0;
               end
            end
            S_WAKE: begin
               if (wake_ok && top_ff) begin
                  level_ff[tid_idx] <= '0;
               end
            end
            S_ACC: begin
               elapsed_ff <= (sum_sat >= period_ff) ? '0 : sum_sat;
            end
            S_BPOP: begin
               // pop the boost level head; the push below requeues it at level 0
               if (boost_tid == tail_ff[bl_ff]) begin
                  nonempty_ff[bl_ff] <= 1'b0;
               end
               level_ff[boost_tid] <= '0;
            end
            S_EVENT: begin
               if (action_ff == ACT_QEND) begin
                  level_ff[running_ff] <= dem_lvl;
               end
            end
            S_POP: begin
               if (pop_tid == tail_ff[pick_ff]) begin
                  nonempty_ff[pick_ff] <= 1'b0;
               end
               queued_ff[pop_tid] <= 1'b0;
               running_ff         <= pop_tid;
               if (action_ff == ACT_EXIT) begin
                  inuse_ff[prev_ff] <= 1'b0;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               elapsed_ff <= elapsed_ff;
            end
         endcase

         // tail push, last so it wins over the pop in the boost walk
         if (push_en) begin
            nonempty_ff[push_lvl] <= 1'b1;
            queued_ff[push_tid]   <= 1'b1;
         end
      end
   end

   // payload and queue pointers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= action_type'(req_tuser);
         tid_ff    <= req_tdata[3:0];
         tleft_ff  <= req_tdata[27:4];
         top_ff    <= req_tdata[28];
         newid_ff  <= '0;
         slice_ff  <= '0;
      end

      case (state_ff)
         S_CREATE: begin
            status_ff <= free_any ? ST_ACCEPTED : ST_FULL;
            newid_ff  <= free_any ? ID_W'(free_id) : '0;
         end
         S_WAKE:      status_ff <= ST_ACCEPTED;
         S_ACC_SLICE: slice_ff  <= slice_sat;
         S_ACC:       bl_ff     <= LVL_W'(1);
         S_BSCAN: begin
            if (!nonempty_ff[bl_ff] && 32'(bl_ff) != LEVELS - 1) begin
               bl_ff <= bl_ff + LVL_W'(1);
            end
         end
         S_BPOP: begin
            if (boost_tid != tail_ff[bl_ff]) begin
               head_ff[bl_ff] <= link_rdata;
            end
         end
         S_EVENT: prev_ff <= running_ff;
         S_PICK: begin
            pick_ff  <= top_lvl;
            slice_ff <= '0;
            case (action_ff)
               ACT_YIELD: status_ff <= ST_KEEP;
               ACT_EXIT:  status_ff <= ST_NONE;
               default:   status_ff <= ST_DEADLOCK;
            endcase
         end
         S_POP: begin
            if (pop_tid != tail_ff[pick_ff]) begin
               head_ff[pick_ff] <= link_rdata;
            end
            status_ff <= (pop_tid == prev_ff) ? ST_KEEP : ST_SWITCH;
         end
         S_OUT_SLICE: begin
            slice_ff <= slice_sat;
            if (action_ff == ACT_NOP) begin
               status_ff <= ST_KEEP;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_user_ff <= status_ff;
               rsp_data_ff <= {newid_ff, slice_ff, ID_W'(running_ff)};
            end
         end
         default: begin
            pick_ff <= pick_ff;
         end
      endcase

      if (push_en) begin
         if (!nonempty_ff[push_lvl]) begin
            head_ff[push_lvl] <= push_tid;
         end
         tail_ff[push_lvl] <= push_tid;
      end
   end

endmodule

FILE: rtl/mlfq_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "multilevel_feedback_queue_scheduler_defines.svh"
module mlfq_checker
   import mlfq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   logic req_fire;
   logic no_slice;

   assign req_fire = req_tvalid && req_tready;
   assign no_slice = (rsp_tuser == ST_NONE) || (rsp_tuser == ST_DEADLOCK) ||
                     (rsp_tuser == ST_ACCEPTED) || (rsp_tuser == ST_FULL);

   // a stalled result holds
   `MLFQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // one request in flight at a time
   `MLFQ_ASSERT_NEXT(a_one_inflight, clock, reset, req_fire, !req_tready)

   // no slice is loaded when nothing is scheduled
   `MLFQ_ASSERT_IMPLY(a_zero_quantum, clock, reset, rsp_tvalid && no_slice, rsp_tdata[27:4] == 24'd0)

   // a new id appears only with an accepted create
   `MLFQ_ASSERT_IMPLY(a_newid, clock, reset, rsp_tvalid && rsp_tuser != ST_ACCEPTED, rsp_tdata[31:28] == 4'd0)

endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_mlfq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/tb_multilevel_feedback_queue_scheduler.sv
// Testbench: self-checking stimulus and scoreboard for the feedback queue scheduler.
`timescale 1ns / 1ps
module tb_multilevel_feedback_queue_scheduler;
   import mlfq_pkg::*;

   localparam int NTHR   = 16;
   localparam int NLVL   = 15;
   localparam int WDOG   = 20000;
   localparam int SETTLE = 64;

   typedef struct packed {
      action_type  action;
      logic [3:0]  tid;
      logic [23:0] time_left;
      logic        to_top;
   } sched_req_t;

   typedef struct packed {
      status_type  status;
      logic [3:0]  next_thread;
      logic [23:0] quantum;
      logic [3:0]  new_id;
   } sched_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   multilevel_feedback_queue_scheduler u_dut (.*);

   always #5 clock = ~clock;

   // Predictor state: a plain ordered list per level replaces the linked queues.
   logic [19:0] m_base;
   logic [31:0] m_period;
   logic [3:0]  m_run;
   logic [31:0] m_elapsed;
   logic [3:0]  m_level[NTHR];
   logic        m_used[NTHR];
   logic        m_queued[NTHR];
   logic [3:0]  m_fifo[NLVL][$];

   sched_req_t  pending_reqs[$];
   sched_rsp_t  expected_rsps[$];
   int          errors = 0;
   int          rsp_count = 0;
   int          hold_off = 0;   // long receiver stall, counted by the stall process
   logic        hold_rsp = 1'b0;
   int          idle_cycles = 0;

   function automatic logic [23:0] slice_for(input logic [3:0] lvl);
      logic [47:0] q;
      q = 48'(m_base) * 48'(lvl + 1);
      return (q > 48'hFFFFFF) ? 24'hFFFFFF : q[23:0];
   endfunction

   function automatic void enqueue(input logic [3:0] t, input logic [3:0] lvl);
      m_fifo[lvl].push_back(t);
      m_queued[t] = 1'b1;
   endfunction

   function automatic bit pick_head(output logic [3:0] t);
      t = '0;
      for (int l = 0; l < NLVL; l++) begin
         if (m_fifo[l].size() != 0) begin
            t = m_fifo[l].pop_front();
            m_queued[t] = 1'b0;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void reset_sched();
      m_base = BASE_RESET;
      m_period = PERIOD_RESET;
      m_run = '0;
      m_elapsed = '0;
      for (int i = 0; i < NTHR; i++) begin
         m_level[i] = '0;
         m_used[i] = (i == 0);
         m_queued[i] = 1'b0;
      end
      for (int l = 0; l < NLVL; l++) m_fifo[l].delete();
   endfunction

   // Compute the response of one request and advance the predicted state.
   function automatic sched_rsp_t schedule(input sched_req_t r);
      sched_rsp_t  o;
      logic [3:0]  prev, nxt;
      logic [23:0] qprev, used;
      logic [32:0] sum;
      o = '{status: ST_KEEP, next_thread: '0, quantum: '0, new_id: '0};
      prev = m_run;
      case (r.action)
         ACT_CREATE: begin
            o.status = ST_FULL;
            for (int i = 0; i < NTHR; i++) begin
               if (!m_used[i]) begin
                  m_used[i] = 1'b1;
                  m_level[i] = '0;
                  enqueue(4'(i), '0);
                  o.new_id = 4'(i);
                  o.status = ST_ACCEPTED;
                  break;
               end
            end
         end
         ACT_WAKE: begin
            o.status = ST_ACCEPTED;
            if (m_used[r.tid] && r.tid != m_run && !m_queued[r.tid]) begin
               if (r.to_top) m_level[r.tid] = '0;
               enqueue(r.tid, m_level[r.tid]);
            end
         end
         ACT_NOP: begin
            o.quantum = slice_for(m_level[prev]);
         end
         default: begin
            qprev = slice_for(m_level[prev]);
            used = (r.time_left > qprev) ? '0 : qprev - r.time_left;
            sum = {1'b0, m_elapsed} + 33'(used);
            m_elapsed = sum[32] ? 32'hFFFFFFFF : sum[31:0];
            if (m_elapsed >= m_period) begin
               for (int l = 1; l < NLVL; l++) begin
                  while (m_fifo[l].size() != 0) begin
                     nxt = m_fifo[l].pop_front();
                     m_level[nxt] = '0;
                     m_fifo[0].push_back(nxt);
                  end
               end
               m_elapsed = '0;
            end
            if (r.action == ACT_QEND) begin
               if (m_level[prev] + 1 < NLVL) m_level[prev]++;
               enqueue(prev, m_level[prev]);
               void'(pick_head(nxt));
               m_run = nxt;
               o.status = (nxt == prev) ? ST_KEEP : ST_SWITCH;
            end else if (r.action == ACT_YIELD) begin
               if (pick_head(nxt)) begin
                  enqueue(prev, m_level[prev]);
                  m_run = nxt;
                  o.status = (nxt == prev) ? ST_KEEP : ST_SWITCH;
               end
            end else if (pick_head(nxt)) begin
               if (r.action == ACT_EXIT) m_used[prev] = 1'b0;
               m_run = nxt;
               o.status = (nxt == prev) ? ST_KEEP : ST_SWITCH;
            end else begin
               o.status = (r.action == ACT_EXIT) ? ST_NONE : ST_DEADLOCK;
            end
            if (o.status == ST_SWITCH || o.status == ST_KEEP)
               o.quantum = slice_for(m_level[m_run]);
         end
      endcase
      o.next_thread = m_run;
      return o;
   endfunction

   // Driver: offer pending requests with a random gap before each one.
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(schedule(pending_reqs.pop_front()));
            send_gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
         end
         if (req_tvalid && !req_tready) begin
            // hold the current request
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_reqs[0].action;
            req_tdata  <= {3'b000, pending_reqs[0].to_top, pending_reqs[0].time_left,
                           pending_reqs[0].tid};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall process: count down a long receiver hold-off.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         hold_rsp <= 1'b1;
      end else begin
         hold_rsp <= 1'b0;
      end
   end

   // Monitor: compare each response with the oldest expectation.
   int rsp_wait = 0;
   always @(posedge clock) begin
      sched_rsp_t got, exp_rsp;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: status_type'(rsp_tuser), next_thread: rsp_tdata[3:0],
                    quantum: rsp_tdata[27:4], new_id: rsp_tdata[31:28]};
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, got);
               errors++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (got.status != exp_rsp.status) begin
                  $display("%0t: status exp %0d got %0d", $time, exp_rsp.status, got.status);
                  errors++;
               end
               if (got.next_thread != exp_rsp.next_thread) begin
                  $display("%0t: next_thread exp %0d got %0d", $time,
                           exp_rsp.next_thread, got.next_thread);
                  errors++;
               end
               if (got.quantum != exp_rsp.quantum) begin
                  $display("%0t: quantum exp %0d got %0d", $time, exp_rsp.quantum,
                           got.quantum);
                  errors++;
               end
               if (got.new_id != exp_rsp.new_id) begin
                  $display("%0t: new_thread_id exp %0d got %0d", $time, exp_rsp.new_id,
                           got.new_id);
                  errors++;
               end
            end
            rsp_wait = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) rsp_wait = 0;
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing is accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WDOG) begin
            $display("tb_multilevel_feedback_queue_scheduler failed");
            $finish;
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_BASE_QUANTUM) m_base = val[19:0];
      else m_period = val;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic sched_req_t make_req(input action_type a, input logic [3:0] t,
                                           input logic [23:0] tl, input logic top);
      return '{action: a, tid: t, time_left: tl, to_top: top};
   endfunction

   // Mostly valid traffic with thread churn; some noise on every field.
   task automatic queue_random(input int n);
      action_type a;
      logic [23:0] tl;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: a = ACT_QEND;
            5, 6, 7:       a = ACT_YIELD;
            8:             a = ACT_EXIT;
            9:             a = ACT_JOIN;
            10:            a = ACT_MUTEX;
            11, 12, 13:    a = ACT_CREATE;
            19:            a = ACT_NOP;
            default:       a = ACT_WAKE;
         endcase
         case ($urandom_range(0, 3))
            0:       tl = $urandom_range(0, 24'hFFFFFF);
            1:       tl = '0;
            default: tl = $urandom_range(0, 300);
         endcase
         pending_reqs.push_back(make_req(a, 4'($urandom), tl, 1'($urandom)));
      end
   endtask

   initial begin
      reset_sched();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: every action, an empty queue, a full table, extreme fields.
      pending_reqs.push_back(make_req(ACT_YIELD, 4'd0, 24'd0, 1'b0));
      pending_reqs.push_back(make_req(ACT_EXIT, 4'd0, 24'd0, 1'b0));
      pending_reqs.push_back(make_req(ACT_JOIN, 4'd0, 24'hFFFFFF, 1'b0));
      pending_reqs.push_back(make_req(ACT_MUTEX, 4'd15, 24'd5, 1'b1));
      pending_reqs.push_back(make_req(ACT_QEND, 4'd0, 24'd0, 1'b0));
      pending_reqs.push_back(make_req(ACT_NOP, 4'd7, 24'd0, 1'b1));
      pending_reqs.push_back(make_req(ACT_WAKE, 4'd0, 24'd0, 1'b1));
      pending_reqs.push_back(make_req(ACT_WAKE, 4'd9, 24'd0, 1'b0));
      for (int i = 0; i < 16; i++)
         pending_reqs.push_back(make_req(ACT_CREATE, 4'd0, 24'd0, 1'b0));
      pending_reqs.push_back(make_req(ACT_QEND, 4'd3, 24'd100, 1'b0));
      drain();

      // Settings sweep: extremes of both registers, small periods force boosts.
      write_csr(CSR_BASE_QUANTUM, 32'd1);
      write_csr(CSR_BOOST_PERIOD, 32'd1);
      queue_random(200);
      drain();
      write_csr(CSR_BASE_QUANTUM, 32'hFFFFF);
      write_csr(CSR_BOOST_PERIOD, 32'hFFFFFFFF);
      queue_random(300);
      // Long receiver stall while requests keep coming, so the block backs up.
      hold_off = 300;
      drain();
      write_csr(CSR_BASE_QUANTUM, 32'd37);
      write_csr(CSR_BOOST_PERIOD, 32'd500);
      queue_random(400);
      drain();
      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_BASE_QUANTUM, $urandom_range(1, 20'hFFFFF));
         write_csr(CSR_BOOST_PERIOD, (p % 2) ? $urandom : $urandom_range(1, 100000));
         queue_random(200);
         drain();
      end

      $display("Covered %0d responses over seven register settings, boosts,", rsp_count);
      $display("full thread table, empty queues and a long output stall.");
      if (errors == 0) begin
         $display("tb_multilevel_feedback_queue_scheduler passed");
      end else begin
         $display("tb_multilevel_feedback_queue_scheduler failed");
      end
      $finish;
   end
endmodule
